// ----- hdl/gha_pkg.sv -----
// Shared types, field widths and codes of the generational handle allocator.
package gha_pkg;

   localparam int SLOTS     = 1024;
   localparam int GEN_BITS  = 16;
   localparam int IDX_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 10;
   localparam int GEN_W     = 16;

   localparam logic [CNT_BITS-1:0] SLOTS_CNT = CNT_BITS'(SLOTS);

   localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] handle_index;
      logic [GEN_W-1:0]   handle_generation;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                live;
      logic [INDEX_W-1:0]  new_index;
      logic [GEN_W-1:0]    new_generation;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic gen_read;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

// ----- hdl/gha_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/gha_ctrl.sv -----
// Sequencer of the allocator: capture, slot lookup, execute and commit.
module gha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gha_pkg::dp_status_type dp_status,
   output gha_pkg::ctrl_cmd_type  cmd
);
   import gha_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SLOT,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            cmd.gen_read = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            // hold until the result register can take the item
            if (dp_status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/gha_datapath.sv -----
// Counters, stack and generation memories, result logic and result register.
module gha_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gha_pkg::req_type       req_payload,
   input  gha_pkg::ctrl_cmd_type  cmd,
   output gha_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gha_pkg::rsp_type       rsp_payload
);
   import gha_pkg::*;

   req_type              item_ff;
   logic [CNT_BITS-1:0]  top_ff, top_in;
   logic [CNT_BITS-1:0]  free_ff, free_in;
   logic [CNT_BITS-1:0]  max_top_ff, max_top_in;
   logic [IDX_BITS-1:0]  slot_ff, slot_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [IDX_BITS-1:0]  stack_rd_data;
   logic                 stack_wr_en;
   logic [GEN_BITS-1:0]  gen_rd_data;
   logic                 gen_wr_en;
   logic [GEN_BITS-1:0]  gen_wr_data;
   logic [GEN_BITS-1:0]  gen_value;
   logic                 idx_live;
   logic [CNT_BITS-1:0]  free_dec;

   assign free_dec = free_ff - 1'b1;

   gha_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (free_ff[IDX_BITS-1:0]),
      .wr_data (item_ff.handle_index[IDX_BITS-1:0]),
      .rd_en   (cmd.capture),
      .rd_addr (free_dec[IDX_BITS-1:0]),
      .rd_data (stack_rd_data)
   );

   gha_ram #(
      .WIDTH (GEN_BITS),
      .DEPTH (SLOTS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (slot_ff),
      .wr_data (gen_wr_data),
      .rd_en   (cmd.gen_read),
      .rd_addr (slot_in),
      .rd_data (gen_rd_data)
   );

   // pick the slot whose generation is needed
   always_comb begin
      if (item_ff.mode == MODE_CREATE) begin
         if (free_ff != '0) begin
            slot_in = stack_rd_data;
         end else begin
            slot_in = top_ff[IDX_BITS-1:0];
         end
      end else begin
         slot_in = item_ff.handle_index[IDX_BITS-1:0];
      end
   end

   always_comb begin
      // entries at or above the fill mark were never written and read as zero
      gen_value   = (CNT_BITS'(slot_ff) < max_top_ff) ? gen_rd_data : '0;
      idx_live    = (CNT_BITS'(item_ff.handle_index) < top_ff) &&
                    (item_ff.handle_generation == GEN_W'(gen_value));
      gen_wr_data = GEN_BITS'(gen_value + 1'b1);
      top_in      = top_ff;
      free_in     = free_ff;
      max_top_in  = max_top_ff;
      stack_wr_en = 1'b0;
      gen_wr_en   = 1'b0;
      rsp_in      = '0;
      case (item_ff.mode)
         MODE_CHECK: begin
            if (idx_live) begin
               rsp_in.live = 1'b1;
            end else begin
               rsp_in.status = STATUS_DEAD;
            end
         end
         MODE_CREATE: begin
            if (free_ff != '0) begin
               free_in               = free_dec;
               rsp_in.new_index      = INDEX_W'(slot_ff);
               rsp_in.new_generation = GEN_W'(gen_value);
            end else if (top_ff < SLOTS_CNT) begin
               top_in = top_ff + 1'b1;
               if (top_ff == max_top_ff) begin
                  // first use of this slot since reset: seed its generation with zero
                  max_top_in  = max_top_ff + 1'b1;
                  gen_wr_en   = cmd.commit;
                  gen_wr_data = '0;
               end
               rsp_in.new_index      = INDEX_W'(slot_ff);
               rsp_in.new_generation = GEN_W'(gen_value);
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         MODE_DELETE: begin
            if (!idx_live) begin
               rsp_in.status = STATUS_DEAD;
            end else begin
               rsp_in.live = 1'b1;
               gen_wr_en   = cmd.commit;
               if (CNT_BITS'(item_ff.handle_index) + 1'b1 == top_ff) begin
                  top_in = top_ff - 1'b1;
               end else if (free_ff < SLOTS_CNT) begin
                  stack_wr_en = cmd.commit;
                  free_in     = free_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign dp_status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         free_ff      <= '0;
         max_top_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            top_ff     <= top_in;
            free_ff    <= free_in;
            max_top_ff <= max_top_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      if (cmd.gen_read) begin
         slot_ff <= slot_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still held");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (free_ff <= SLOTS_CNT) && (top_ff <= max_top_ff) && (max_top_ff <= SLOTS_CNT))
      else $error("allocator counters out of range");

   a_fill_mark_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (max_top_ff >= $past(max_top_ff)))
      else $error("generation fill mark went backwards");

endmodule

// ----- hdl/generational_handle_allocator_unit.sv -----
// Top level of the generational handle allocator: controller plus datapath.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  gha_pkg::req_type (mode, index, generation)
//  rsp      out        rsp_valid/rsp_stall  gha_pkg::rsp_type (status, live, new handle)
//
// Each item goes from acceptance to a loaded result through capture with
// the free-stack read, slot choice with the generation read, then execute and
// commit. The two dependent registered memory reads keep these steps apart.
// Reset clears the counters; no clearing pass runs, as the generation store
// reads zero above a high-water fill mark and a slot's generation is written
// as zero when the mark first passes it.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in execute until that register frees.
module generational_handle_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gha_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gha_pkg::rsp_type rsp_payload
);
   import gha_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequence each item through capture, lookup and commit
   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // hold the counters, memories and the result register
   gha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
